// ===== rtl/core/jerk_limited_scurve_planner_core_macros.svh =====
// Assertion helpers for the RTL of the S-curve planner core.
`ifndef JERK_LIMITED_SCURVE_PLANNER_CORE_MACROS_SVH
`define JERK_LIMITED_SCURVE_PLANNER_CORE_MACROS_SVH

`ifndef SYNTH

`define JLSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jlsp assertion failed");

`define JLSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jlsp assertion failed");

`else

`define JLSP_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define JLSP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/jlsp_pkg.sv =====
`timescale 1ns / 1ps

package jlsp_pkg;

  localparam int VAL_W = 63;
  localparam logic [VAL_W-1:0] MAXV = {VAL_W{1'b1}};

  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_MULDIV = 2'd0,
    OP_MULSH  = 2'd1,
    OP_SQRT   = 2'd2
  } au_op_t;

  typedef struct packed {
    logic        start;
    au_op_t      op;
    logic        sh1;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } au_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] res;
  } au_rsp_t;

endpackage

// ===== rtl/core/jerk_limited_scurve_planner_core.sv =====
`timescale 1ns / 1ps

// Jerk-limited seven-segment S-curve planner.
// Input channel (in_valid / in_stall): one beat per move carrying start, end and
// peak speed and move length, all unsigned Q31.32. The block stalls the input while a move
// is being planned and takes the next beat once it is back in idle.
// Output channel (out_valid / out_stall): one to seven beats per move, one per
// segment in time order; out_last_segment marks the final beat. A bad or
// infeasible move gives a single beat carrying the status code.
// Configuration channel (cfg_valid / cfg_ready): index 0 writes max_accel and
// index 1 writes max_jerk; other indexes are ignored. Writes are always taken.
// Multiplies, divides and roots run through one shared unit: a 32x32 multiplier
// that builds the full product from partial products, followed by a shift or by a
// one-bit-per-cycle divider or square root. A move whose peak speed does not fit
// runs up to BISECT_ITERS steps of bisection, each one a distance evaluation.
// A result register sits between the planner and the output, so the planner keeps
// working while a segment waits; it only holds when a second segment is ready.
// Reset returns both limits to 1.0 and drops any move in progress.
module jerk_limited_scurve_planner_core #(
  parameter int FRAC_BITS    = 32,
  parameter int BISECT_ITERS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [62:0]                  in_start_speed,
  input  logic [62:0]                  in_end_speed,
  input  logic [62:0]                  in_peak_speed,
  input  logic [62:0]                  in_move_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status_code,
  output logic [2:0]                   out_seg_type,
  output logic [62:0]                  out_seg_duration,
  output logic signed [63:0]           out_seg_position,
  output logic signed [63:0]           out_seg_speed,
  output logic signed [63:0]           out_seg_accel,
  output logic signed [63:0]           out_seg_jerk,
  output logic [62:0]                  out_reached_speed,
  output logic [62:0]                  out_accel_peak_up,
  output logic [62:0]                  out_accel_peak_down,
  output logic                         out_last_segment,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [jlsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [62:0]                  cfg_wdata
);
  import jlsp_pkg::*;

  `include "jerk_limited_scurve_planner_core_macros.svh"

  localparam logic [63:0] ONE     = 64'd1 << FRAC_BITS;
  localparam logic [63:0] SIX_ONE = 64'd6 << FRAC_BITS;
  localparam int          ITW     = $clog2(BISECT_ITERS + 1);

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_INFEAS = 2'd2;

  localparam logic [2:0] SEG_JUP_ACC   = 3'd0;
  localparam logic [2:0] SEG_CONST_ACC = 3'd1;
  localparam logic [2:0] SEG_JDN_ACC   = 3'd2;
  localparam logic [2:0] SEG_CRUISE    = 3'd3;
  localparam logic [2:0] SEG_JDN_DEC   = 3'd4;
  localparam logic [2:0] SEG_CONST_DEC = 3'd5;
  localparam logic [2:0] SEG_JUP_DEC   = 3'd6;
  localparam logic [2:0] SEG_NONE      = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_JERK  = CFG_IDX_W'(1);

  localparam int NS = 40;

  typedef enum logic [NS-1:0] {
    S_IDLE   = NS'(1) << 0,
    S_CHECK  = NS'(1) << 1,
    S_BAD    = NS'(1) << 2,
    S_INF    = NS'(1) << 3,
    S_DVTRI  = NS'(1) << 4,
    S_TJA    = NS'(1) << 5,
    S_FEAS   = NS'(1) << 6,
    S_FULL   = NS'(1) << 7,
    S_CT     = NS'(1) << 8,
    S_BIS    = NS'(1) << 9,
    S_BIS2   = NS'(1) << 10,
    S_PRE1   = NS'(1) << 11,
    S_PRE2   = NS'(1) << 12,
    S_PRE3   = NS'(1) << 13,
    S_SIDE   = NS'(1) << 14,
    S_A1     = NS'(1) << 15,
    S_H      = NS'(1) << 16,
    S_E1     = NS'(1) << 17,
    S_P1     = NS'(1) << 18,
    S_P2     = NS'(1) << 19,
    S_E2     = NS'(1) << 20,
    S_G      = NS'(1) << 21,
    S_P3     = NS'(1) << 22,
    S_P4     = NS'(1) << 23,
    S_E3     = NS'(1) << 24,
    S_P5     = NS'(1) << 25,
    S_P6     = NS'(1) << 26,
    S_P7     = NS'(1) << 27,
    S_CRU    = NS'(1) << 28,
    S_CRUP   = NS'(1) << 29,
    S_FIN    = NS'(1) << 30,
    S_NONE   = NS'(1) << 31,
    PD_A     = NS'(1) << 32,
    PD_B     = NS'(1) << 33,
    PD_C     = NS'(1) << 34,
    TM_START = NS'(1) << 35,
    TM_TA    = NS'(1) << 36,
    TM_SQ    = NS'(1) << 37,
    TM_TJ    = NS'(1) << 38,
    TM_DIST  = NS'(1) << 39
  } state_t;

  function automatic logic [62:0] sat_add(input logic [62:0] x, input logic [62:0] y);
    logic [63:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[63] ? MAXV : s[62:0];
  endfunction

  function automatic logic [62:0] adj(input logic [62:0] x, input logic [62:0] d,
                                      input logic up);
    logic [62:0] r;
    if (up) begin
      r = sat_add(x, d);
    end else begin
      r = (x > d) ? (x - d) : '0;
    end
    return r;
  endfunction

  state_t        state_r;
  state_t        tm_ret_r;
  state_t        pd_ret_r;
  logic          op_pend_r;

  logic [62:0]   max_accel_r;
  logic [62:0]   max_jerk_r;
  logic [62:0]   v0_r;
  logic [62:0]   v1_r;
  logic [62:0]   vp_r;
  logic [62:0]   len_r;
  logic [62:0]   vm_r;
  logic [62:0]   dvtri_r;
  logic [62:0]   tja_r;

  logic [62:0]   tm_vs_r;
  logic [62:0]   tm_ve_r;
  logic [62:0]   tm_tj_r;
  logic [62:0]   tm_ta_r;
  logic [62:0]   tm_ap_r;
  logic [62:0]   tm_dist_r;

  logic [62:0]   pd_mid_r;
  logic [62:0]   pd_d1_r;
  logic [62:0]   pd_res_r;

  logic [62:0]   lo_r;
  logic [62:0]   hi_r;
  logic [ITW-1:0] iter_r;
  logic [62:0]   vhat_r;
  logic [62:0]   ct_r;

  logic [62:0]   s1_tj_r;
  logic [62:0]   s1_ta_r;
  logic [62:0]   s2_tj_r;
  logic [62:0]   s2_ta_r;
  logic [62:0]   apu_r;
  logic [62:0]   apd_r;

  logic          side_r;
  logic          any_r;
  logic [62:0]   a1_r;
  logic [62:0]   h_r;
  logic [62:0]   g_r;
  logic [62:0]   p_r;
  logic [62:0]   v_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [2:0]    out_type_r;
  logic [62:0]   out_dur_r;
  logic [63:0]   out_pos_r;
  logic [63:0]   out_spd_r;
  logic [63:0]   out_acc_r;
  logic [63:0]   out_jerk_r;
  logic [62:0]   out_reached_r;
  logic [62:0]   out_apu_r;
  logic [62:0]   out_apd_r;
  logic          out_last_r;

  au_req_t       au_req;
  au_rsp_t       au_rsp;
  logic          uses_au;
  logic          au_fire;

  logic [62:0]   tm_dv;
  logic [63:0]   tm_sum;
  logic [62:0]   tm_t;
  logic [62:0]   bs_tj;
  logic [62:0]   bs_ta;
  logic          bs_up;
  logic          s2_empty;
  logic [63:0]   sa;
  logic [63:0]   sj;
  logic [62:0]   bis_diff;
  logic [62:0]   bis_mid;
  logic          bad_move;

  logic          out_free;
  logic          emit_st;
  logic          emit_go;
  logic [1:0]    e_status;
  logic [2:0]    e_type;
  logic [62:0]   e_dur;
  logic [63:0]   e_acc;
  logic [63:0]   e_jerk;
  logic [62:0]   e_reached;
  logic          e_last;

  jlsp_arith #(
    .FRAC_BITS(FRAC_BITS)
  ) u_arith (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (au_req),
    .rsp  (au_rsp)
  );

  assign tm_dv    = (tm_vs_r > tm_ve_r) ? (tm_vs_r - tm_ve_r) : (tm_ve_r - tm_vs_r);
  assign tm_sum   = {1'b0, tm_vs_r} + {1'b0, tm_ve_r};
  assign tm_t     = sat_add(sat_add(tm_tj_r, tm_tj_r), tm_ta_r);
  assign bs_tj    = side_r ? s2_tj_r : s1_tj_r;
  assign bs_ta    = side_r ? s2_ta_r : s1_ta_r;
  assign bs_up    = side_r ? (v1_r >= vhat_r) : (vhat_r >= v0_r);
  assign s2_empty = (s2_tj_r == '0) && (s2_ta_r == '0);
  assign sa       = bs_up ? {1'b0, a1_r} : (64'd0 - {1'b0, a1_r});
  assign sj       = bs_up ? {1'b0, max_jerk_r} : (64'd0 - {1'b0, max_jerk_r});
  assign bis_diff = hi_r - lo_r;
  assign bis_mid  = lo_r + (bis_diff >> 1);
  assign bad_move = (vp_r == '0) || (len_r == '0) || (max_accel_r == '0) ||
                    (max_jerk_r == '0) || (v0_r > vp_r) || (v1_r > vp_r);

  always_comb begin
    uses_au = 1'b1;
    au_req.op  = OP_MULSH;
    au_req.sh1 = 1'b0;
    au_req.a   = '0;
    au_req.b   = '0;
    au_req.c   = '0;
    unique case (state_r)
      S_DVTRI: begin
        au_req.op = OP_MULDIV;
        au_req.a  = {1'b0, max_accel_r};
        au_req.b  = {1'b0, max_accel_r};
        au_req.c  = {1'b0, max_jerk_r};
      end
      S_TJA: begin
        au_req.op = OP_MULDIV;
        au_req.a  = {1'b0, max_accel_r};
        au_req.b  = ONE;
        au_req.c  = {1'b0, max_jerk_r};
      end
      S_CT: begin
        au_req.op = OP_MULDIV;
        au_req.a  = {1'b0, len_r - pd_res_r};
        au_req.b  = ONE;
        au_req.c  = {1'b0, vp_r};
      end
      TM_TA: begin
        au_req.op = OP_MULDIV;
        au_req.a  = {1'b0, tm_dv - dvtri_r};
        au_req.b  = ONE;
        au_req.c  = {1'b0, max_accel_r};
      end
      TM_SQ: begin
        au_req.op = OP_SQRT;
        au_req.a  = {1'b0, max_jerk_r};
        au_req.b  = {1'b0, tm_dv};
      end
      TM_TJ: begin
        au_req.op = OP_MULDIV;
        au_req.a  = {1'b0, tm_ap_r};
        au_req.b  = ONE;
        au_req.c  = {1'b0, max_jerk_r};
      end
      TM_DIST: begin
        au_req.sh1 = 1'b1;
        au_req.a   = tm_sum;
        au_req.b   = {1'b0, tm_t};
      end
      S_A1: begin
        au_req.a = {1'b0, max_jerk_r};
        au_req.b = {1'b0, bs_tj};
      end
      S_H: begin
        au_req.a = {1'b0, a1_r};
        au_req.b = {1'b0, bs_tj};
      end
      S_P1, S_P5: begin
        au_req.a = {1'b0, v_r};
        au_req.b = {1'b0, bs_tj};
      end
      S_P2, S_P7: begin
        au_req.op = OP_MULDIV;
        au_req.a  = {1'b0, h_r};
        au_req.b  = {1'b0, bs_tj};
        au_req.c  = SIX_ONE;
      end
      S_G: begin
        au_req.a = {1'b0, a1_r};
        au_req.b = {1'b0, bs_ta};
      end
      S_P3: begin
        au_req.a = {1'b0, v_r};
        au_req.b = {1'b0, bs_ta};
      end
      S_P4: begin
        au_req.sh1 = 1'b1;
        au_req.a   = {1'b0, g_r};
        au_req.b   = {1'b0, bs_ta};
      end
      S_P6: begin
        au_req.sh1 = 1'b1;
        au_req.a   = {1'b0, h_r};
        au_req.b   = {1'b0, bs_tj};
      end
      S_CRUP: begin
        au_req.a = {1'b0, v_r};
        au_req.b = {1'b0, ct_r};
      end
      default: begin
        uses_au = 1'b0;
      end
    endcase
    au_req.start = uses_au && !op_pend_r;
  end

  assign au_fire = op_pend_r && au_rsp.done;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    emit_st   = 1'b1;
    e_status  = ST_OK;
    e_type    = SEG_NONE;
    e_dur     = '0;
    e_acc     = '0;
    e_jerk    = '0;
    e_reached = vhat_r;
    e_last    = 1'b1;
    unique case (state_r)
      S_BAD: begin
        e_status  = ST_BAD;
        e_reached = '0;
      end
      S_INF: begin
        e_status  = ST_INFEAS;
        e_reached = vm_r;
      end
      S_NONE: begin
        e_type = SEG_NONE;
      end
      S_E1: begin
        e_type = bs_up ? SEG_JUP_ACC : SEG_JDN_DEC;
        e_dur  = bs_tj;
        e_jerk = sj;
        e_last = 1'b0;
      end
      S_E2: begin
        e_type = bs_up ? SEG_CONST_ACC : SEG_CONST_DEC;
        e_dur  = bs_ta;
        e_acc  = sa;
        e_last = 1'b0;
      end
      S_E3: begin
        e_type = bs_up ? SEG_JDN_ACC : SEG_JUP_DEC;
        e_dur  = bs_tj;
        e_acc  = sa;
        e_jerk = 64'd0 - sj;
        e_last = side_r || ((ct_r == '0) && s2_empty);
      end
      S_CRU: begin
        emit_st = (ct_r != '0);
        e_type  = SEG_CRUISE;
        e_dur   = ct_r;
        e_last  = s2_empty;
      end
      default: begin
        emit_st = 1'b0;
      end
    endcase
  end

  assign emit_go = emit_st && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      max_accel_r <= ONE[62:0];
      max_jerk_r  <= ONE[62:0];
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_MAX_ACCEL) begin
          max_accel_r <= cfg_wdata;
        end else if (cfg_index == CFG_MAX_JERK) begin
          max_jerk_r <= cfg_wdata;
        end
      end

      if (au_req.start) begin
        op_pend_r <= 1'b1;
      end else if (au_fire) begin
        op_pend_r <= 1'b0;
      end

      if (emit_go) begin
        out_valid_r   <= 1'b1;
        out_status_r  <= e_status;
        out_type_r    <= e_type;
        out_dur_r     <= e_dur;
        out_pos_r     <= (e_type == SEG_NONE) ? 64'd0 : {1'b0, p_r};
        out_spd_r     <= (e_type == SEG_NONE) ? 64'd0 : {1'b0, v_r};
        out_acc_r     <= e_acc;
        out_jerk_r    <= e_jerk;
        out_reached_r <= e_reached;
        out_apu_r     <= (e_status == ST_OK) ? apu_r : '0;
        out_apd_r     <= (e_status == ST_OK) ? apd_r : '0;
        out_last_r    <= e_last;
        any_r         <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            v0_r    <= in_start_speed;
            v1_r    <= in_end_speed;
            vp_r    <= in_peak_speed;
            len_r   <= in_move_length;
            vm_r    <= (in_start_speed > in_end_speed) ? in_start_speed : in_end_speed;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          state_r <= bad_move ? S_BAD : S_DVTRI;
        end
        S_BAD, S_INF, S_NONE: begin
          if (emit_go) begin
            state_r <= S_IDLE;
          end
        end
        S_DVTRI: begin
          if (au_fire) begin
            dvtri_r <= au_rsp.res;
            state_r <= S_TJA;
          end
        end
        S_TJA: begin
          if (au_fire) begin
            tja_r    <= au_rsp.res;
            pd_mid_r <= vm_r;
            pd_ret_r <= S_FEAS;
            state_r  <= PD_A;
          end
        end
        S_FEAS: begin
          if (len_r < pd_res_r) begin
            state_r <= S_INF;
          end else begin
            pd_mid_r <= vp_r;
            pd_ret_r <= S_FULL;
            state_r  <= PD_A;
          end
        end
        S_FULL: begin
          if (len_r >= pd_res_r) begin
            vhat_r  <= vp_r;
            state_r <= S_CT;
          end else begin
            lo_r    <= vm_r;
            hi_r    <= vp_r;
            iter_r  <= '0;
            state_r <= S_BIS;
          end
        end
        S_CT: begin
          if (au_fire) begin
            ct_r    <= au_rsp.res;
            state_r <= S_PRE1;
          end
        end
        S_BIS: begin
          if (iter_r == ITW'(BISECT_ITERS) || bis_diff <= 63'd1) begin
            vhat_r  <= bis_mid;
            ct_r    <= '0;
            state_r <= S_PRE1;
          end else begin
            pd_mid_r <= bis_mid;
            pd_ret_r <= S_BIS2;
            state_r  <= PD_A;
          end
        end
        S_BIS2: begin
          if (pd_res_r > len_r) begin
            hi_r <= pd_mid_r;
          end else begin
            lo_r <= pd_mid_r;
          end
          iter_r  <= iter_r + ITW'(1);
          state_r <= S_BIS;
        end
        S_PRE1: begin
          tm_vs_r  <= v0_r;
          tm_ve_r  <= vhat_r;
          tm_ret_r <= S_PRE2;
          state_r  <= TM_START;
        end
        S_PRE2: begin
          s1_tj_r  <= tm_tj_r;
          s1_ta_r  <= tm_ta_r;
          apu_r    <= ((tm_tj_r | tm_ta_r) != '0) ? tm_ap_r : '0;
          tm_vs_r  <= vhat_r;
          tm_ve_r  <= v1_r;
          tm_ret_r <= S_PRE3;
          state_r  <= TM_START;
        end
        S_PRE3: begin
          s2_tj_r <= tm_tj_r;
          s2_ta_r <= tm_ta_r;
          apd_r   <= ((tm_tj_r | tm_ta_r) != '0) ? tm_ap_r : '0;
          p_r     <= '0;
          v_r     <= v0_r;
          side_r  <= 1'b0;
          any_r   <= 1'b0;
          state_r <= S_SIDE;
        end
        S_SIDE: begin
          if (bs_tj == '0 && bs_ta == '0) begin
            state_r <= side_r ? S_FIN : S_CRU;
          end else begin
            state_r <= S_A1;
          end
        end
        S_A1: begin
          if (au_fire) begin
            a1_r    <= au_rsp.res;
            state_r <= S_H;
          end
        end
        S_H: begin
          if (au_fire) begin
            h_r     <= au_rsp.res;
            state_r <= S_E1;
          end
        end
        S_E1: begin
          if (emit_go) begin
            state_r <= S_P1;
          end
        end
        S_P1, S_P3, S_P5: begin
          if (au_fire) begin
            p_r <= sat_add(p_r, au_rsp.res);
            unique case (state_r)
              S_P1:    state_r <= S_P2;
              S_P3:    state_r <= S_P4;
              default: state_r <= S_P6;
            endcase
          end
        end
        S_P2: begin
          if (au_fire) begin
            p_r     <= adj(p_r, au_rsp.res, bs_up);
            v_r     <= adj(v_r, h_r >> 1, bs_up);
            state_r <= (bs_ta != '0) ? S_E2 : S_E3;
          end
        end
        S_E2: begin
          if (emit_go) begin
            state_r <= S_G;
          end
        end
        S_G: begin
          if (au_fire) begin
            g_r     <= au_rsp.res;
            state_r <= S_P3;
          end
        end
        S_P4: begin
          if (au_fire) begin
            p_r     <= adj(p_r, au_rsp.res, bs_up);
            v_r     <= adj(v_r, g_r, bs_up);
            state_r <= S_E3;
          end
        end
        S_E3: begin
          if (emit_go) begin
            state_r <= S_P5;
          end
        end
        S_P6: begin
          if (au_fire) begin
            p_r     <= adj(p_r, au_rsp.res, bs_up);
            state_r <= S_P7;
          end
        end
        S_P7: begin
          if (au_fire) begin
            p_r     <= adj(p_r, au_rsp.res, !bs_up);
            v_r     <= adj(v_r, h_r - (h_r >> 1), bs_up);
            state_r <= side_r ? S_FIN : S_CRU;
          end
        end
        S_CRU: begin
          if (ct_r == '0) begin
            side_r  <= 1'b1;
            state_r <= S_SIDE;
          end else if (emit_go) begin
            state_r <= S_CRUP;
          end
        end
        S_CRUP: begin
          if (au_fire) begin
            p_r     <= sat_add(p_r, au_rsp.res);
            side_r  <= 1'b1;
            state_r <= S_SIDE;
          end
        end
        S_FIN: begin
          state_r <= any_r ? S_IDLE : S_NONE;
        end
        PD_A: begin
          tm_vs_r  <= v0_r;
          tm_ve_r  <= pd_mid_r;
          tm_ret_r <= PD_B;
          state_r  <= TM_START;
        end
        PD_B: begin
          pd_d1_r  <= tm_dist_r;
          tm_vs_r  <= pd_mid_r;
          tm_ve_r  <= v1_r;
          tm_ret_r <= PD_C;
          state_r  <= TM_START;
        end
        PD_C: begin
          pd_res_r <= sat_add(pd_d1_r, tm_dist_r);
          state_r  <= pd_ret_r;
        end
        TM_START: begin
          tm_ta_r <= '0;
          if (tm_dv == '0) begin
            tm_tj_r   <= '0;
            tm_ap_r   <= '0;
            tm_dist_r <= '0;
            state_r   <= tm_ret_r;
          end else if (tm_dv >= dvtri_r) begin
            tm_tj_r <= tja_r;
            tm_ap_r <= max_accel_r;
            state_r <= TM_TA;
          end else begin
            state_r <= TM_SQ;
          end
        end
        TM_TA: begin
          if (au_fire) begin
            tm_ta_r <= au_rsp.res;
            state_r <= TM_DIST;
          end
        end
        TM_SQ: begin
          if (au_fire) begin
            tm_ap_r <= au_rsp.res;
            state_r <= TM_TJ;
          end
        end
        TM_TJ: begin
          if (au_fire) begin
            tm_tj_r <= au_rsp.res;
            state_r <= TM_DIST;
          end
        end
        TM_DIST: begin
          if (au_fire) begin
            tm_dist_r <= au_rsp.res;
            state_r   <= tm_ret_r;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid           = out_valid_r;
  assign out_status_code     = out_status_r;
  assign out_seg_type        = out_type_r;
  assign out_seg_duration    = out_dur_r;
  assign out_seg_position    = out_pos_r;
  assign out_seg_speed       = out_spd_r;
  assign out_seg_accel       = out_acc_r;
  assign out_seg_jerk        = out_jerk_r;
  assign out_reached_speed   = out_reached_r;
  assign out_accel_peak_up   = out_apu_r;
  assign out_accel_peak_down = out_apd_r;
  assign out_last_segment    = out_last_r;

  `JLSP_ASSERT_IMP(a_done_when_pending, clk, rst_n, au_rsp.done, op_pend_r)
  `JLSP_ASSERT_NXT(a_accept_starts_check, clk, rst_n, in_valid && !in_stall, state_r == S_CHECK)
  `JLSP_ASSERT_IMP(a_error_is_last, clk, rst_n, out_valid && out_status_code != ST_OK, out_last_segment)
  `JLSP_ASSERT_IMP(a_bisect_ordered, clk, rst_n, state_r == S_BIS, hi_r >= lo_r)

endmodule

// ===== rtl/core/jlsp_arith.sv =====
`timescale 1ns / 1ps

module jlsp_arith #(
  parameter int FRAC_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  jlsp_pkg::au_req_t req,
  output jlsp_pkg::au_rsp_t rsp
);
  import jlsp_pkg::*;

  localparam int SH0 = FRAC_BITS;
  localparam int SH1 = FRAC_BITS + 1;

  typedef enum logic [5:0] {
    A_IDLE  = 6'b000001,
    A_MUL   = 6'b000010,
    A_ROUTE = 6'b000100,
    A_DIV   = 6'b001000,
    A_SQRT  = 6'b010000,
    A_DONE  = 6'b100000
  } ast_t;

  ast_t             ast_r;
  au_op_t           op_r;
  logic             sh1_r;
  logic [63:0]      a_r;
  logic [63:0]      b_r;
  logic [63:0]      c_r;
  logic [127:0]     acc_r;
  logic [66:0]      rem_r;
  logic [63:0]      q_r;
  logic [5:0]       cnt_r;
  logic [VAL_W-1:0] res_r;

  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] acc_nxt;
  logic [127:0] shifted;
  logic [64:0]  d_pre;
  logic         d_ge;
  logic [63:0]  d_rem_nxt;
  logic [66:0]  s_pre;
  logic [66:0]  s_trial;
  logic         s_ge;
  logic [66:0]  s_rem_nxt;
  logic [63:0]  q_nxt;

  assign a_half = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = cnt_r[0] ? b_r[63:32] : b_r[31:0];
  assign pp     = a_half * b_half;

  always_comb begin
    case (2'(cnt_r[1]) + 2'(cnt_r[0]))
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  assign acc_nxt = acc_r + pp_sh;
  assign shifted = sh1_r ? (acc_r >> SH1) : (acc_r >> SH0);

  assign d_pre     = {rem_r[63:0], acc_r[63]};
  assign d_ge      = d_pre >= {1'b0, c_r};
  assign d_rem_nxt = d_ge ? 64'(d_pre - {1'b0, c_r}) : d_pre[63:0];

  assign s_pre     = {rem_r[64:0], acc_r[127:126]};
  assign s_trial   = {1'b0, q_r, 2'b01};
  assign s_ge      = s_pre >= s_trial;
  assign s_rem_nxt = s_ge ? (s_pre - s_trial) : s_pre;

  assign q_nxt = {q_r[62:0], (ast_r == A_SQRT) ? s_ge : d_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ast_r <= A_IDLE;
    end else begin
      unique case (ast_r)
        A_IDLE: begin
          if (req.start) begin
            op_r  <= req.op;
            sh1_r <= req.sh1;
            a_r   <= req.a;
            b_r   <= req.b;
            c_r   <= req.c;
            acc_r <= '0;
            cnt_r <= '0;
            ast_r <= A_MUL;
          end
        end
        A_MUL: begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r[1:0] == 2'd3) begin
            ast_r <= A_ROUTE;
          end
        end
        A_ROUTE: begin
          cnt_r <= '0;
          q_r   <= '0;
          case (op_r)
            OP_MULDIV: begin
              if (c_r == 64'd0 || acc_r[127:64] >= c_r) begin
                res_r <= MAXV;
                ast_r <= A_DONE;
              end else begin
                rem_r <= {3'd0, acc_r[127:64]};
                ast_r <= A_DIV;
              end
            end
            OP_SQRT: begin
              rem_r <= '0;
              ast_r <= A_SQRT;
            end
            default: begin
              res_r <= (shifted[127:63] != '0) ? MAXV : shifted[62:0];
              ast_r <= A_DONE;
            end
          endcase
        end
        A_DIV: begin
          rem_r <= {3'd0, d_rem_nxt};
          q_r   <= q_nxt;
          acc_r <= {acc_r[126:0], 1'b0};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            res_r <= q_nxt[63] ? MAXV : q_nxt[62:0];
            ast_r <= A_DONE;
          end
        end
        A_SQRT: begin
          rem_r <= s_rem_nxt;
          q_r   <= q_nxt;
          acc_r <= {acc_r[125:0], 2'b00};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            res_r <= q_nxt[62:0];
            ast_r <= A_DONE;
          end
        end
        A_DONE: begin
          ast_r <= A_IDLE;
        end
        default: begin
          ast_r <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = (ast_r == A_DONE);
  assign rsp.res  = res_r;

endmodule

// ===== tb/tb_jerk_limited_scurve_planner_core.sv =====
`timescale 1ns / 1ps

module tb_jerk_limited_scurve_planner_core;
  import jlsp_pkg::*;

  localparam logic [63:0] VMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE = 64'h1_0000_0000;
  localparam int WATCH_LIMIT = 200000;
  localparam int HOLD_CYCLES = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL = 0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_JERK = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2;

  typedef enum logic [1:0] {ST_OK = 2'd0, ST_BAD = 2'd1, ST_INFEASIBLE = 2'd2} status_t;
  typedef enum logic [2:0] {
    SEG_JERK_UP_ACC = 3'd0, SEG_CONST_ACC = 3'd1, SEG_JERK_DN_ACC = 3'd2,
    SEG_CRUISE = 3'd3, SEG_JERK_DN_DEC = 3'd4, SEG_CONST_DEC = 3'd5,
    SEG_JERK_UP_DEC = 3'd6, SEG_NONE = 3'd7
  } seg_kind_t;
  typedef enum int {ROW_PREDICT, ROW_BAD, ROW_INFEASIBLE} row_kind_t;

  typedef struct {
    logic [1:0]  status;
    logic [2:0]  stype;
    logic [62:0] dur;
    logic [63:0] pos;
    logic [63:0] spd;
    logic [63:0] acc;
    logic [63:0] jrk;
    logic [62:0] reached;
    logic [62:0] apu;
    logic [62:0] apd;
    logic        last;
  } segment_t;

  typedef struct {
    logic [63:0] tj;
    logic [63:0] ta;
    logic [63:0] ap;
    logic [63:0] span;
  } side_t;

  typedef struct {
    logic [63:0] acc;
    logic [63:0] jrk;
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] vp;
    logic [63:0] len;
    row_kind_t   kind;
  } move_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [62:0] in_start_speed = '0;
  logic [62:0] in_end_speed = '0;
  logic [62:0] in_peak_speed = '0;
  logic [62:0] in_move_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status_code;
  logic [2:0] out_seg_type;
  logic [62:0] out_seg_duration;
  logic signed [63:0] out_seg_position;
  logic signed [63:0] out_seg_speed;
  logic signed [63:0] out_seg_accel;
  logic signed [63:0] out_seg_jerk;
  logic [62:0] out_reached_speed;
  logic [62:0] out_accel_peak_up;
  logic [62:0] out_accel_peak_down;
  logic out_last_segment;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [62:0] cfg_wdata = '0;

  jerk_limited_scurve_planner_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_start_speed(in_start_speed), .in_end_speed(in_end_speed),
    .in_peak_speed(in_peak_speed), .in_move_length(in_move_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status_code(out_status_code), .out_seg_type(out_seg_type),
    .out_seg_duration(out_seg_duration), .out_seg_position(out_seg_position),
    .out_seg_speed(out_seg_speed), .out_seg_accel(out_seg_accel),
    .out_seg_jerk(out_seg_jerk), .out_reached_speed(out_reached_speed),
    .out_accel_peak_up(out_accel_peak_up), .out_accel_peak_down(out_accel_peak_down),
    .out_last_segment(out_last_segment),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [63:0] accel_lim = ONE;
  logic [63:0] jerk_lim = ONE;
  segment_t segment_q[$];
  segment_t move_segs[$];
  int errors = 0;
  bit hold_req = 1'b0;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  function automatic logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [127:0] p;
    logic [127:0] q;
    if (c == 0) return VMAX;
    p = {64'd0, a} * {64'd0, b};
    q = p / {64'd0, c};
    if (q > {64'd0, VMAX}) return VMAX;
    return q[63:0];
  endfunction

  function automatic logic [63:0] root_of_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] n;
    logic [127:0] c;
    logic [63:0] r;
    r = 0;
    n = {64'd0, a} * {64'd0, b};
    for (int bit_i = 62; bit_i >= 0; bit_i--) begin
      c = {64'd0, r | (64'd1 << bit_i)};
      if (c * c <= n) r = c[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    return (r > VMAX) ? VMAX : r;
  endfunction

  function automatic logic [63:0] step_toward(logic [63:0] x, logic [63:0] d, bit up);
    if (up) return add_sat(x, d);
    return (x > d) ? x - d : 64'd0;
  endfunction

  function automatic side_t side_timing(logic [63:0] vs, logic [63:0] ve);
    side_t s;
    logic [63:0] dv;
    logic [63:0] dvtri;
    logic [63:0] t;
    s = '{0, 0, 0, 0};
    dv = (vs > ve) ? vs - ve : ve - vs;
    if (dv == 0) return s;
    dvtri = mul_div(accel_lim, accel_lim, jerk_lim);
    if (dv >= dvtri) begin
      s.tj = mul_div(accel_lim, ONE, jerk_lim);
      s.ta = mul_div(dv - dvtri, ONE, accel_lim);
      s.ap = accel_lim;
    end else begin
      s.ap = root_of_product(jerk_lim, dv);
      s.tj = mul_div(s.ap, ONE, jerk_lim);
    end
    t = add_sat(add_sat(s.tj, s.tj), s.ta);
    s.span = mul_div(vs + ve, t, 2 * ONE);
    return s;
  endfunction

  function automatic logic [63:0] travel(logic [63:0] v0, logic [63:0] vm, logic [63:0] v1);
    side_t s1;
    side_t s2;
    s1 = side_timing(v0, vm);
    s2 = side_timing(vm, v1);
    return add_sat(s1.span, s2.span);
  endfunction

  function automatic void add_seg(logic [2:0] k, logic [63:0] d, logic [63:0] p,
                                  logic [63:0] v, logic [63:0] a, logic [63:0] j);
    segment_t s;
    s = '{ST_OK, k, d[62:0], p, v, a, j, '0, '0, '0, 1'b0};
    move_segs.push_back(s);
  endfunction

  function automatic void lay_side(input logic [63:0] vs, input logic [63:0] ve,
                                   output logic [63:0] ap,
                                   inout logic [63:0] p, inout logic [63:0] v);
    side_t s;
    bit up;
    logic [63:0] a1;
    logic [63:0] h;
    logic [63:0] g;
    logic [63:0] sa;
    logic [63:0] sj;
    up = (ve >= vs);
    s = side_timing(vs, ve);
    ap = 0;
    if (s.tj == 0 && s.ta == 0) return;
    ap = s.ap;
    a1 = mul_div(jerk_lim, s.tj, ONE);
    h = mul_div(a1, s.tj, ONE);
    sa = up ? a1 : 64'd0 - a1;
    sj = up ? jerk_lim : 64'd0 - jerk_lim;
    add_seg(up ? SEG_JERK_UP_ACC : SEG_JERK_DN_DEC, s.tj, p, v, 64'd0, sj);
    p = add_sat(p, mul_div(v, s.tj, ONE));
    p = step_toward(p, mul_div(h, s.tj, 6 * ONE), up);
    v = step_toward(v, h / 2, up);
    if (s.ta != 0) begin
      add_seg(up ? SEG_CONST_ACC : SEG_CONST_DEC, s.ta, p, v, sa, 64'd0);
      g = mul_div(a1, s.ta, ONE);
      p = add_sat(p, mul_div(v, s.ta, ONE));
      p = step_toward(p, mul_div(g, s.ta, 2 * ONE), up);
      v = step_toward(v, g, up);
    end
    add_seg(up ? SEG_JERK_DN_ACC : SEG_JERK_UP_DEC, s.tj, p, v, sa, 64'd0 - sj);
    p = add_sat(p, mul_div(v, s.tj, ONE));
    p = step_toward(p, mul_div(h, s.tj, 2 * ONE), up);
    p = step_toward(p, mul_div(h, s.tj, 6 * ONE), !up);
    v = step_toward(v, h - h / 2, up);
  endfunction

  function automatic void plan_move(logic [63:0] v0, logic [63:0] v1,
                                    logic [63:0] vp, logic [63:0] len);
    logic [63:0] vm;
    logic [63:0] dfull;
    logic [63:0] vhat;
    logic [63:0] ct;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] apu;
    logic [63:0] apd;
    segment_t s;
    move_segs.delete();
    vm = (v0 > v1) ? v0 : v1;
    ct = 0;
    if (vp == 0 || len == 0 || accel_lim == 0 || jerk_lim == 0 || v0 > vp || v1 > vp) begin
      segment_q.push_back('{ST_BAD, SEG_NONE, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1});
      return;
    end
    if (len < travel(v0, vm, v1)) begin
      segment_q.push_back('{ST_INFEASIBLE, SEG_NONE, '0, '0, '0, '0, '0, vm[62:0], '0, '0,
                            1'b1});
      return;
    end
    dfull = travel(v0, vp, v1);
    if (len >= dfull) begin
      vhat = vp;
      ct = mul_div(len - dfull, ONE, vp);
    end else begin
      lo = vm;
      hi = vp;
      for (int i = 0; i < 64; i++) begin
        if (hi - lo <= 1) break;
        mid = lo + (hi - lo) / 2;
        if (travel(v0, mid, v1) > len) hi = mid;
        else lo = mid;
      end
      vhat = lo + (hi - lo) / 2;
    end
    p = 0;
    v = v0;
    lay_side(v0, vhat, apu, p, v);
    if (ct != 0) begin
      add_seg(SEG_CRUISE, ct, p, v, 64'd0, 64'd0);
      p = add_sat(p, mul_div(v, ct, ONE));
    end
    lay_side(vhat, v1, apd, p, v);
    if (move_segs.size() == 0) add_seg(SEG_NONE, 0, 0, 0, 0, 0);
    foreach (move_segs[k]) begin
      s = move_segs[k];
      s.reached = vhat[62:0];
      s.apu = apu[62:0];
      s.apd = apd[62:0];
      s.last = (k == move_segs.size() - 1);
      segment_q.push_back(s);
    end
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    segment_t e;
    if (out_valid && !out_stall) begin
      if (segment_q.size() == 0) begin
        report("unexpected beat", {61'd0, out_seg_type}, 64'd0);
      end else begin
        e = segment_q.pop_front();
        if (out_status_code !== e.status) report("status_code", out_status_code, e.status);
        if (out_seg_type !== e.stype) report("seg_type", out_seg_type, e.stype);
        if (out_seg_duration !== e.dur) report("seg_duration", out_seg_duration, e.dur);
        if (out_seg_position !== e.pos) report("seg_position", out_seg_position, e.pos);
        if (out_seg_speed !== e.spd) report("seg_speed", out_seg_speed, e.spd);
        if (out_seg_accel !== e.acc) report("seg_accel", out_seg_accel, e.acc);
        if (out_seg_jerk !== e.jrk) report("seg_jerk", out_seg_jerk, e.jrk);
        if (out_reached_speed !== e.reached)
          report("reached_speed", out_reached_speed, e.reached);
        if (out_accel_peak_up !== e.apu) report("accel_peak_up", out_accel_peak_up, e.apu);
        if (out_accel_peak_down !== e.apd)
          report("accel_peak_down", out_accel_peak_down, e.apd);
        if (out_last_segment !== e.last) report("last_segment", out_last_segment, e.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5) - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_move(logic [63:0] v0, logic [63:0] v1, logic [63:0] vp,
                           logic [63:0] len, row_kind_t kind = ROW_PREDICT);
    logic [63:0] vm;
    vm = (v0 > v1) ? v0 : v1;
    in_valid <= 1'b1;
    in_start_speed <= v0[62:0];
    in_end_speed <= v1[62:0];
    in_peak_speed <= vp[62:0];
    in_move_length <= len[62:0];
    plan_move(v0 & VMAX, v1 & VMAX, vp & VMAX, len & VMAX);
    if (kind != ROW_PREDICT) begin
      void'(segment_q.pop_back());
      if (kind == ROW_BAD)
        segment_q.push_back('{ST_BAD, SEG_NONE, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1});
      else
        segment_q.push_back('{ST_INFEASIBLE, SEG_NONE, '0, '0, '0, '0, '0,
                              vm[62:0], '0, '0, 1'b1});
    end
    do @(posedge clk); while (in_stall);
    if (!quiet && !hold_req && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (segment_q.size() != 0 || in_stall) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[62:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MAX_ACCEL) accel_lim = data & VMAX;
    else if (idx == REG_MAX_JERK) jerk_lim = data & VMAX;
    @(posedge clk);
  endtask

  task automatic set_limits(logic [63:0] a, logic [63:0] j);
    drain();
    write_reg(REG_MAX_ACCEL, a);
    write_reg(REG_MAX_JERK, j);
  endtask

  function automatic logic [63:0] rand63();
    return {1'b0, 31'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [63:0] part_of(logic [63:0] v);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return v;
    return mul_div(v, {32'd0, 32'($urandom)}, ONE);
  endfunction

  task automatic send_random;
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] vp;
    logic [63:0] len;
    logic [63:0] dmin;
    logic [63:0] dfull;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_move(rand63(), rand63(), rand63(), rand63());
      return;
    end
    vp = {32'd0, 32'($urandom_range(1, 200))} * ONE + {32'd0, 32'($urandom)};
    v0 = part_of(vp);
    v1 = part_of(vp);
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0: vp = 0;
        1: v0 = vp + 1 + $urandom_range(0, 1000);
        2: v1 = vp + 1 + $urandom_range(0, 1000);
        default: begin
          send_move(v0, v1, vp, 0);
          return;
        end
      endcase
      send_move(v0, v1, vp, 64'd10 * ONE);
      return;
    end
    dmin = travel(v0, (v0 > v1) ? v0 : v1, v1);
    dfull = travel(v0, vp, v1);
    r = $urandom_range(0, 9);
    if (r == 0 && dmin > 1) begin
      len = mul_div(dmin, {32'd0, 32'($urandom)}, ONE);
      if (len == 0) len = 1;
    end else if (r < 4 && dfull > dmin) begin
      len = dmin + mul_div(dfull - dmin, {32'd0, 32'($urandom)}, ONE);
    end else begin
      len = add_sat(dfull, mul_div(dfull, {32'd0, 32'($urandom)}, ONE));
      len = add_sat(len, $urandom_range(0, 3) == 0 ? 64'd0 : {32'd0, 32'($urandom)});
    end
    if (len == 0) len = 1;
    send_move(v0, v1, vp, len);
  endtask

  move_row_t rows[] = '{
    '{ONE, ONE, 0, 0, 0, 10 * ONE, ROW_BAD},
    '{ONE, ONE, 0, 0, ONE, 0, ROW_BAD},
    '{ONE, ONE, 2 * ONE, 0, ONE, 10 * ONE, ROW_BAD},
    '{ONE, ONE, 0, 2 * ONE, ONE, 10 * ONE, ROW_BAD},
    '{ONE, ONE, 0, 10 * ONE, 10 * ONE, 1, ROW_INFEASIBLE},
    '{ONE, ONE, 5 * ONE, 5 * ONE, 5 * ONE, 10 * ONE, ROW_PREDICT},
    '{ONE, ONE, 3 * ONE, 3 * ONE, 3 * ONE, 1, ROW_PREDICT},
    '{ONE, ONE, 0, 0, ONE, 100 * ONE, ROW_PREDICT},
    '{ONE, ONE, 0, 0, 10 * ONE, 20 * ONE, ROW_PREDICT},
    '{ONE, ONE, ONE, 3 * ONE, 4 * ONE, 8 * ONE, ROW_PREDICT},
    '{ONE, ONE, 2 * ONE, 0, 2 * ONE, VMAX, ROW_PREDICT},
    '{ONE, ONE, 0, 0, 1, VMAX, ROW_PREDICT},
    '{ONE, ONE, VMAX, VMAX, VMAX, VMAX, ROW_PREDICT},
    '{ONE, ONE, 0, 0, VMAX, VMAX, ROW_PREDICT},
    '{0, ONE, 0, 0, ONE, 10 * ONE, ROW_BAD},
    '{ONE, 0, 0, 0, ONE, 10 * ONE, ROW_BAD},
    '{VMAX, VMAX, 0, VMAX, VMAX, VMAX, ROW_PREDICT},
    '{VMAX, VMAX, 0, ONE, 2 * ONE, 3 * ONE, ROW_PREDICT},
    '{64'd256, 64'd1 << 50, 0, ONE, ONE, VMAX, ROW_PREDICT},
    '{4 * ONE, ONE, 0, ONE, ONE, 100 * ONE, ROW_PREDICT},
    '{ONE, 64'd1 << 40, ONE, 0, 3 * ONE, 50 * ONE, ROW_PREDICT}
  };

  logic [63:0] phase_acc[6] = '{ONE, 0, ONE, VMAX, 64'd256, 10 * ONE};
  logic [63:0] phase_jrk[6] = '{ONE, ONE, 0, VMAX, 64'd1 << 50, 50 * ONE};
  int phase_items[6] = '{40, 5, 5, 25, 25, 45};

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].acc != accel_lim || rows[i].jrk != jerk_lim)
        set_limits(rows[i].acc, rows[i].jrk);
      send_move(rows[i].v0, rows[i].v1, rows[i].vp, rows[i].len, rows[i].kind);
    end
    for (int ph = 0; ph < 6; ph++) begin
      set_limits(phase_acc[ph], phase_jrk[ph]);
      if (ph == 0) write_reg(REG_SPARE, rand63());
      if (ph == 5) quiet = 1'b1;
      for (int n = 0; n < phase_items[ph]; n++) begin
        if (ph == 0 && n == 3) hold_req = 1'b1;
        send_random();
      end
    end
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
